// ----- rtl/core/strict_priority_multi_fifo_queue_defines.svh -----
// assertion macros shared by the queue controller and datapath
// no dependencies; each macro expands to one concurrent assertion on clk and arst_n
`ifndef STRICT_PRIORITY_MULTI_FIFO_QUEUE_DEFINES_SVH
`define STRICT_PRIORITY_MULTI_FIFO_QUEUE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SPMQ_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("queue assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SPMQ_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("queue assertion failed");

`endif

// ----- rtl/core/spmq_pkg.sv -----
// shared constants, types and command struct of the strict priority queue
// no dependencies
`default_nettype none

package spmq_pkg;

	localparam int LEVELS       = 4;
	localparam int MAX_CAPACITY = 64;
	localparam int HANDLE_BITS  = 32;

	localparam int LEVEL_W = $clog2(LEVELS);
	localparam int PTR_W   = $clog2(MAX_CAPACITY);
	localparam int CNT_W   = PTR_W + 1;
	localparam int ADDR_W  = LEVEL_W + PTR_W;
	localparam int SLOTS   = LEVELS * (2 ** PTR_W);

	// fixed field widths of the ports
	localparam int CFG_W    = 7;
	localparam int PRIO_W   = 8;
	localparam int STATUS_W = 3;
	localparam int OUTLVL_W = 4;
	localparam int OCC_W    = 7;

	typedef enum logic [1:0] {
		OP_ENQ   = 2'd0,
		OP_DEQ   = 2'd1,
		OP_STOP  = 2'd2,
		OP_DRAIN = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_DONE         = 3'd0,
		STS_REJECT       = 3'd1,
		STS_FULL         = 3'd2,
		STS_EMPTY        = 3'd3,
		STS_EMPTY_STOPPED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EXEC = 2'd1,
		ST_RESP = 2'd2
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic execute;
		logic respond;
	} ctrl_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/strict_priority_multi_fifo_queue.sv -----
// top level of the strict priority multilevel fifo queue
// depends on spmq_pkg, spmq_ctrl and spmq_dpath
//
//  channel   handshake            payload
//  request   start & !busy        operation, task_handle, task_priority
//  result    done (one cycle)     status, out_handle, out_level, occupancy,
//                                 dropped_count, is_shut_down
//  config    cfg_we               cfg_wdata (capacity)
//
// every transaction passes through three steps: capture, execute, result strobe;
// the steps are set by the request capture register and the registered read
// of the slot memory, which shares the execute cycle with the level pick
// and pointer update.
// busy is high from acceptance until the result strobe has gone.
// reset clears pointers, counts, the shutdown flag and loads capacity 64;
// the slot memory needs no clearing pass.
// results cannot be stalled: done marks them for exactly one cycle.
`default_nettype none

module strict_priority_multi_fifo_queue (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic [1:0]                             operation,
	input  wire logic [spmq_pkg::HANDLE_BITS-1:0]       task_handle,
	input  wire logic signed [spmq_pkg::PRIO_W-1:0]     task_priority,
	output logic                                        done,
	output logic [spmq_pkg::STATUS_W-1:0]               status,
	output logic [spmq_pkg::HANDLE_BITS-1:0]            out_handle,
	output logic [spmq_pkg::OUTLVL_W-1:0]               out_level,
	output logic [spmq_pkg::OCC_W-1:0]                  occupancy,
	output logic [spmq_pkg::OCC_W-1:0]                  dropped_count,
	output logic                                        is_shut_down,
	input  wire logic                                   cfg_we,
	input  wire logic [spmq_pkg::CFG_W-1:0]             cfg_wdata
);

	spmq_pkg::ctrl_cmd_t cmd;

	// sequencer
	spmq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// queue state and slot storage
	spmq_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.operation     (operation),
		.task_handle   (task_handle),
		.task_priority (task_priority),
		.status        (status),
		.out_handle    (out_handle),
		.out_level     (out_level),
		.occupancy     (occupancy),
		.dropped_count (dropped_count),
		.is_shut_down  (is_shut_down)
	);

endmodule

`default_nettype wire

// ----- rtl/core/spmq_ctrl.sv -----
// controller state machine of the strict priority queue: capture, execute, respond
// depends on spmq_pkg and strict_priority_multi_fifo_queue_defines.svh
`default_nettype none
`include "strict_priority_multi_fifo_queue_defines.svh"

module spmq_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output spmq_pkg::ctrl_cmd_t     cmd,
	output logic                    busy,
	output logic                    done
);

	spmq_pkg::state_t state_q;
	spmq_pkg::state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spmq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			spmq_pkg::ST_IDLE: begin
				if (start) state_nxt = spmq_pkg::ST_EXEC;
			end
			spmq_pkg::ST_EXEC: begin
				state_nxt = spmq_pkg::ST_RESP;
			end
			spmq_pkg::ST_RESP: begin
				state_nxt = spmq_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = spmq_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			spmq_pkg::ST_IDLE: begin
				busy        = 1'b0;
				cmd.capture = start;
			end
			spmq_pkg::ST_EXEC: begin
				cmd.execute = 1'b1;
			end
			spmq_pkg::ST_RESP: begin
				cmd.respond = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	assign done = cmd.respond;

	// accepted transaction keeps the block busy until its result is out
	`SPMQ_ASSERT_NXT(a_accept_busy, start && !busy, busy && cmd.execute)
	// execution is always followed by exactly one result strobe
	`SPMQ_ASSERT_NXT(a_exec_resp, cmd.execute, done)
	`SPMQ_ASSERT_NXT(a_done_single, done, !done && !busy)

endmodule

`default_nettype wire

// ----- rtl/core/spmq_dpath.sv -----
// datapath of the strict priority queue: level rings, counters, slot memory, result regs
// depends on spmq_pkg and strict_priority_multi_fifo_queue_defines.svh
`default_nettype none
`include "strict_priority_multi_fifo_queue_defines.svh"

module spmq_dpath (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire spmq_pkg::ctrl_cmd_t                    cmd,
	input  wire logic                                   cfg_we,
	input  wire logic [spmq_pkg::CFG_W-1:0]             cfg_wdata,
	input  wire logic [1:0]                             operation,
	input  wire logic [spmq_pkg::HANDLE_BITS-1:0]       task_handle,
	input  wire logic signed [spmq_pkg::PRIO_W-1:0]     task_priority,
	output logic [spmq_pkg::STATUS_W-1:0]               status,
	output logic [spmq_pkg::HANDLE_BITS-1:0]            out_handle,
	output logic [spmq_pkg::OUTLVL_W-1:0]               out_level,
	output logic [spmq_pkg::OCC_W-1:0]                  occupancy,
	output logic [spmq_pkg::OCC_W-1:0]                  dropped_count,
	output logic                                        is_shut_down
);

	localparam int LEVELS  = spmq_pkg::LEVELS;
	localparam int LEVEL_W = spmq_pkg::LEVEL_W;
	localparam int PTR_W   = spmq_pkg::PTR_W;
	localparam int CNT_W   = spmq_pkg::CNT_W;
	localparam int ADDR_W  = spmq_pkg::ADDR_W;
	localparam int HW      = spmq_pkg::HANDLE_BITS;

	// pointer advance with wrap at the effective capacity
	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
		input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] n;
		n = {1'b0, p} + CNT_W'(1);
		advance = (n >= cap) ? '0 : n[PTR_W-1:0];
	endfunction

	// control state
	logic [spmq_pkg::CFG_W-1:0] cap_q;
	logic [PTR_W-1:0]           head_q [LEVELS];
	logic [PTR_W-1:0]           tail_q [LEVELS];
	logic [CNT_W-1:0]           cnt_q  [LEVELS];
	logic [CNT_W-1:0]           total_q;
	logic                       stopped_q;

	// captured request and result payload
	spmq_pkg::op_t              op_q;
	logic [HW-1:0]              handle_q;
	logic signed [spmq_pkg::PRIO_W-1:0] prio_q;
	spmq_pkg::status_t          status_q;
	logic [LEVEL_W-1:0]         level_q;
	logic                       deq_ok_q;
	logic [CNT_W-1:0]           dropped_q;
	logic [HW-1:0]              rd_data_q;

	// slot memory
	logic [HW-1:0]              mem [spmq_pkg::SLOTS];

	// combinational decisions
	logic [CNT_W-1:0]           eff_cap;
	logic [LEVEL_W-1:0]         enq_lvl;
	logic [LEVEL_W-1:0]         deq_lvl;
	logic                       found;
	logic                       full;
	logic                       enq_ok;
	logic                       deq_ok;
	spmq_pkg::status_t          res_status;
	logic [LEVEL_W-1:0]         res_level;
	logic [CNT_W-1:0]           res_dropped;
	logic [ADDR_W-1:0]          wr_addr;
	logic [ADDR_W-1:0]          rd_addr;
	logic [PTR_W-1:0]           head_sel;
	logic [PTR_W-1:0]           tail_sel;

	// effective capacity, level clamp, highest non-empty level
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (int'(cap_q) > spmq_pkg::MAX_CAPACITY) begin
			eff_cap = CNT_W'(spmq_pkg::MAX_CAPACITY);
		end else begin
			eff_cap = CNT_W'(cap_q);
		end

		if (int'(prio_q) < 0) begin
			enq_lvl = '0;
		end else if (int'(prio_q) >= LEVELS) begin
			enq_lvl = LEVEL_W'(LEVELS - 1);
		end else begin
			enq_lvl = LEVEL_W'(prio_q);
		end

		found   = 1'b0;
		deq_lvl = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if (cnt_q[l] != '0) begin
				found   = 1'b1;
				deq_lvl = LEVEL_W'(l);
			end
		end

		full     = (total_q >= eff_cap);
		head_sel = head_q[deq_lvl];
		tail_sel = tail_q[enq_lvl];
		wr_addr  = {enq_lvl, tail_sel};
		rd_addr  = {deq_lvl, head_sel};
	end

	// result decode per operation
	always_comb begin
		enq_ok      = 1'b0;
		deq_ok      = 1'b0;
		res_status  = spmq_pkg::STS_DONE;
		res_level   = '0;
		res_dropped = '0;
		case (op_q)
			spmq_pkg::OP_ENQ: begin
				if (stopped_q) begin
					res_status = spmq_pkg::STS_REJECT;
				end else if (full) begin
					res_status = spmq_pkg::STS_FULL;
				end else begin
					enq_ok    = 1'b1;
					res_level = enq_lvl;
				end
			end
			spmq_pkg::OP_DEQ: begin
				if (!found) begin
					res_status = stopped_q ? spmq_pkg::STS_EMPTY_STOPPED
						: spmq_pkg::STS_EMPTY;
				end else begin
					deq_ok    = 1'b1;
					res_level = deq_lvl;
				end
			end
			spmq_pkg::OP_STOP: begin
				res_status = spmq_pkg::STS_DONE;
			end
			spmq_pkg::OP_DRAIN: begin
				res_dropped = total_q;
			end
			default: begin
				res_status = spmq_pkg::STS_DONE;
			end
		endcase
	end

	// capacity register and queue control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= spmq_pkg::CFG_W'(spmq_pkg::MAX_CAPACITY);
			total_q   <= '0;
			stopped_q <= 1'b0;
			for (int l = 0; l < LEVELS; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
				cnt_q[l]  <= '0;
			end
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			if (cmd.execute) begin
				if (op_q == spmq_pkg::OP_STOP) stopped_q <= 1'b1;
				if (enq_ok) total_q <= total_q + CNT_W'(1);
				if (deq_ok && total_q != '0) total_q <= total_q - CNT_W'(1);
				if (op_q == spmq_pkg::OP_DRAIN) total_q <= '0;
				for (int l = 0; l < LEVELS; l++) begin
					if (enq_ok && enq_lvl == LEVEL_W'(l)) begin
						tail_q[l] <= advance(tail_q[l], eff_cap);
						cnt_q[l]  <= cnt_q[l] + CNT_W'(1);
					end
					if (deq_ok && deq_lvl == LEVEL_W'(l)) begin
						head_q[l] <= advance(head_q[l], eff_cap);
						cnt_q[l]  <= cnt_q[l] - CNT_W'(1);
					end
					if (op_q == spmq_pkg::OP_DRAIN) begin
						head_q[l] <= tail_q[l];
						cnt_q[l]  <= '0;
					end
				end
			end
		end
	end

	// request capture and result registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= spmq_pkg::op_t'(operation);
			handle_q <= task_handle;
			prio_q   <= task_priority;
		end
		if (cmd.execute) begin
			status_q  <= res_status;
			level_q   <= res_level;
			deq_ok_q  <= deq_ok;
			dropped_q <= res_dropped;
		end
	end

	// slot memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.execute && enq_ok) mem[wr_addr] <= handle_q;
		if (cmd.execute && deq_ok) rd_data_q <= mem[rd_addr];
	end

	// result ports
	assign status        = status_q;
	assign out_handle    = deq_ok_q ? rd_data_q : '0;
	assign out_level     = spmq_pkg::OUTLVL_W'(level_q);
	assign occupancy     = spmq_pkg::OCC_W'(total_q);
	assign dropped_count = spmq_pkg::OCC_W'(dropped_q);
	assign is_shut_down  = stopped_q;

	// drain leaves nothing held
	`SPMQ_ASSERT_NXT(a_drain_empty, cmd.execute && op_q == spmq_pkg::OP_DRAIN,
		total_q == '0)
	// accepted enqueue grows occupancy by one
	`SPMQ_ASSERT_NXT(a_enq_grow, cmd.execute && enq_ok,
		total_q == $past(total_q) + CNT_W'(1))
	// a popped handle is only reported with a done status
	`SPMQ_ASSERT_IMP(a_pop_done, cmd.respond && deq_ok_q,
		status_q == spmq_pkg::STS_DONE)

endmodule

`default_nettype wire

// ----- test/tb_strict_priority_multi_fifo_queue.sv -----
// testbench for strict_priority_multi_fifo_queue: directed and random transactions
// checked field by field against a ring-level queue model held in a small class
// depends on spmq_pkg and the strict_priority_multi_fifo_queue rtl
module tb_strict_priority_multi_fifo_queue;

	import spmq_pkg::*;

	// one expected result of the queue
	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic [HANDLE_BITS-1:0] handle;
		logic [OUTLVL_W-1:0]    level;
		logic [OCC_W-1:0]       occ;
		logic [OCC_W-1:0]       dropped;
		logic                   shut;
	} queue_result_t;

	// ring-per-level queue model and the results it still owes
	class task_queue_model;
		logic [HANDLE_BITS-1:0] ring_slots [LEVELS][MAX_CAPACITY];
		bit                     slot_written [LEVELS][MAX_CAPACITY];
		int                     head_ptr [LEVELS];
		int                     tail_ptr [LEVELS];
		int                     level_cnt [LEVELS];
		int                     held_total;
		bit                     shut_down;
		int                     capacity_reg;
		queue_result_t          pending_results [$];
		int                     errors;

		function new();
			for (int l = 0; l < LEVELS; l++) begin
				head_ptr[l] = 0;
				tail_ptr[l] = 0;
				level_cnt[l] = 0;
				for (int s = 0; s < MAX_CAPACITY; s++) begin
					ring_slots[l][s] = '0;
					slot_written[l][s] = 1'b0;
				end
			end
			held_total = 0;
			shut_down = 1'b0;
			capacity_reg = 64;
			errors = 0;
		endfunction

		// zero acts as one, anything above the ring size acts as the ring size
		function int ring_len();
			if (capacity_reg == 0)
				return 1;
			if (capacity_reg > MAX_CAPACITY)
				return MAX_CAPACITY;
			return capacity_reg;
		endfunction

		function int step_ptr(int p);
			return (p + 1 >= ring_len()) ? 0 : p + 1;
		endfunction

		function void set_capacity(logic [CFG_W-1:0] v);
			capacity_reg = int'(v);
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction

		// level a dequeue would pop from, or -1 when nothing is held
		function int top_level();
			for (int l = LEVELS - 1; l >= 0; l--)
				if (level_cnt[l] != 0)
					return l;
			return -1;
		endfunction

		// a dequeue must never read a slot that no enqueue has filled since reset
		function bit pop_reads_written();
			int l;
			l = top_level();
			if (l < 0)
				return 1'b1;
			return slot_written[l][head_ptr[l]];
		endfunction

		function void note_request(op_t op, logic [HANDLE_BITS-1:0] h,
				logic signed [PRIO_W-1:0] p);
			queue_result_t r;
			int            l;
			r = '0;
			r.status = STS_DONE;
			case (op)
				OP_ENQ: begin
					if (shut_down) begin
						r.status = STS_REJECT;
					end else if (held_total >= ring_len()) begin
						r.status = STS_FULL;
					end else begin
						// clamp the signed priority into the level range
						if (p < 0)
							l = 0;
						else if (p >= LEVELS)
							l = LEVELS - 1;
						else
							l = int'(p);
						ring_slots[l][tail_ptr[l]] = h;
						slot_written[l][tail_ptr[l]] = 1'b1;
						tail_ptr[l] = step_ptr(tail_ptr[l]);
						level_cnt[l]++;
						held_total++;
						r.level = OUTLVL_W'(l);
					end
				end
				OP_DEQ: begin
					l = top_level();
					if (l < 0) begin
						r.status = shut_down ? STS_EMPTY_STOPPED : STS_EMPTY;
					end else begin
						r.handle = ring_slots[l][head_ptr[l]];
						head_ptr[l] = step_ptr(head_ptr[l]);
						level_cnt[l]--;
						if (held_total != 0)
							held_total--;
						r.level = OUTLVL_W'(l);
					end
				end
				OP_STOP: begin
					shut_down = 1'b1;
				end
				default: begin
					// drain: every head jumps to its tail
					r.dropped = OCC_W'(held_total);
					for (int k = 0; k < LEVELS; k++) begin
						head_ptr[k] = tail_ptr[k];
						level_cnt[k] = 0;
					end
					held_total = 0;
				end
			endcase
			r.occ = OCC_W'(held_total);
			r.shut = shut_down;
			pending_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [HANDLE_BITS-1:0] want,
				logic [HANDLE_BITS-1:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic [HANDLE_BITS-1:0] h,
				logic [OUTLVL_W-1:0] lvl, logic [OCC_W-1:0] occ,
				logic [OCC_W-1:0] drop, logic shut);
			queue_result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: result with no transaction outstanding, expected none actual %0h",
					$time, h);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("status", 32'(want.status), 32'(st));
			compare_field("out_handle", want.handle, h);
			compare_field("out_level", 32'(want.level), 32'(lvl));
			compare_field("occupancy", 32'(want.occ), 32'(occ));
			compare_field("dropped_count", 32'(want.dropped), 32'(drop));
			compare_field("is_shut_down", 32'(want.shut), 32'(shut));
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [1:0]                    operation;
	logic [HANDLE_BITS-1:0]        task_handle;
	logic signed [PRIO_W-1:0]      task_priority;
	logic                          done;
	logic [STATUS_W-1:0]           status;
	logic [HANDLE_BITS-1:0]        out_handle;
	logic [OUTLVL_W-1:0]           out_level;
	logic [OCC_W-1:0]              occupancy;
	logic [OCC_W-1:0]              dropped_count;
	logic                          is_shut_down;
	logic                          cfg_we;
	logic [CFG_W-1:0]              cfg_wdata;

	task_queue_model sb;

	strict_priority_multi_fifo_queue dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.task_handle   (task_handle),
		.task_priority (task_priority),
		.done          (done),
		.status        (status),
		.out_handle    (out_handle),
		.out_level     (out_level),
		.occupancy     (occupancy),
		.dropped_count (dropped_count),
		.is_shut_down  (is_shut_down),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	// clock
	always #10 clk = ~clk;

	// monitor: check results, then note newly accepted transactions
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(status, out_handle, out_level, occupancy, dropped_count,
					is_shut_down);
			if (start && !busy)
				sb.note_request(op_t'(operation), task_handle, task_priority);
		end
	end

	// run limit
	initial begin
		#4000000;
		$display("strict_priority_multi_fifo_queue: mismatch");
		$finish;
	end

	// present one transaction at a falling edge and hold it until accepted;
	// returns on a falling edge with start still high
	task automatic send_item(input op_t op, input logic [HANDLE_BITS-1:0] h,
			input logic signed [PRIO_W-1:0] p);
		operation <= op;
		task_handle <= h;
		task_priority <= p;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// wait for every outstanding result, plus a margin
	task automatic settle();
		while (sb.outstanding() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// capacity write while the queue is idle
	task automatic write_capacity(input logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_capacity(v);
	endtask

	// random traffic in bursts with random gaps
	task automatic run_random(input int n_items, input int enq_pct, input bit allow_stop);
		int                       sent;
		int                       burst;
		int                       r;
		op_t                      op;
		logic signed [PRIO_W-1:0] prio;
		sent = 0;
		while (sent < n_items) begin
			burst = ($urandom_range(0, 9) == 0) ? int'($urandom_range(20, 40))
				: int'($urandom_range(1, 8));
			for (int b = 0; b < burst && sent < n_items; b++) begin
				r = int'($urandom_range(0, 99));
				if (r < enq_pct)
					op = OP_ENQ;
				else if (r >= 97)
					op = OP_DRAIN;
				else if (r >= 93 && allow_stop)
					op = OP_STOP;
				else
					op = OP_DEQ;
				// keep dequeues off slots never filled since reset
				if (op == OP_DEQ && !sb.pop_reads_written())
					op = OP_DRAIN;
				prio = ($urandom_range(0, 3) == 0) ? PRIO_W'($urandom_range(0, 255))
					: PRIO_W'($urandom_range(0, 3));
				send_item(op, $urandom(), prio);
				sent++;
			end
			start <= 1'b0;
			// now and then hold off until the queue has answered everything
			if ($urandom_range(0, 7) == 0) begin
				do @(negedge clk); while (sb.outstanding() != 0);
			end else begin
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
	endtask

	// stimulus
	initial begin
		logic [CFG_W-1:0] cap_plan [10];
		logic [CFG_W-1:0] cap;

		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_ENQ;
		task_handle = '0;
		task_priority = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cap_plan[0] = 7'd127;
		cap_plan[1] = 7'd1;
		cap_plan[2] = 7'd2;
		cap_plan[3] = 7'd64;
		cap_plan[4] = 7'd3;
		cap_plan[5] = 7'd5;
		cap_plan[6] = 7'd0;
		cap_plan[7] = 7'd16;
		cap_plan[8] = 7'd63;
		cap_plan[9] = 7'd100;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty queue, then priority extremes and clamping
		write_capacity(7'd64);
		send_item(OP_DEQ, '0, '0);
		send_item(OP_DRAIN, '0, '0);
		send_item(OP_ENQ, 32'h0000_0000, -8'sd128);
		send_item(OP_ENQ, 32'hFFFF_FFFF, 8'sd127);
		send_item(OP_ENQ, $urandom(), 8'sd1);
		send_item(OP_ENQ, $urandom(), 8'sd2);
		send_item(OP_ENQ, $urandom(), 8'sd3);
		send_item(OP_ENQ, $urandom(), 8'sd4);
		send_item(OP_ENQ, $urandom(), -8'sd1);
		// highest level first, oldest first within a level
		send_item(OP_DEQ, '0, '0);
		send_item(OP_DEQ, '0, '0);
		send_item(OP_DEQ, '0, '0);
		send_item(OP_DEQ, '0, '0);
		send_item(OP_DRAIN, '0, '0);
		start <= 1'b0;
		settle();

		// capacity zero behaves as one
		write_capacity(7'd0);
		send_item(OP_ENQ, $urandom(), 8'sd2);
		send_item(OP_ENQ, $urandom(), 8'sd3);
		send_item(OP_DEQ, '0, '0);
		send_item(OP_DEQ, '0, '0);
		start <= 1'b0;
		settle();

		// random phases across capacity settings, no shutdown yet
		for (int ph = 0; ph < 11; ph++) begin
			cap = (ph < 10) ? cap_plan[ph] : CFG_W'($urandom_range(1, 64));
			write_capacity(cap);
			run_random(100, int'($urandom_range(30, 80)), 1'b0);
			settle();
		end

		// shutdown: full queue, rejected enqueue, held tasks still handed out
		write_capacity(7'd2);
		send_item(OP_DRAIN, '0, '0);
		send_item(OP_ENQ, $urandom(), 8'sd0);
		send_item(OP_ENQ, $urandom(), 8'sd3);
		send_item(OP_ENQ, $urandom(), 8'sd1);
		send_item(OP_STOP, '0, '0);
		send_item(OP_ENQ, $urandom(), 8'sd2);
		send_item(OP_STOP, '0, '0);
		send_item(OP_DEQ, '0, '0);
		send_item(OP_DEQ, '0, '0);
		send_item(OP_DEQ, '0, '0);
		send_item(OP_DRAIN, '0, '0);
		start <= 1'b0;
		settle();

		write_capacity(7'd4);
		run_random(100, 50, 1'b1);

		// let the last transactions come back
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		if (sb.errors == 0) begin
			$display("strict_priority_multi_fifo_queue: match");
		end else begin
			$display("strict_priority_multi_fifo_queue: mismatch");
		end
		$finish;
	end

endmodule
